// ===== design/mtuf_pkg.sv =====
// Shared types, constants and helpers for the merge tree union-find block.
// No dependencies.
`timescale 1ns / 1ps

package mtuf_pkg;

	localparam int NV  = 1024;              // vertex capacity
	localparam int MD  = 8;                 // neighbor slots per vertex
	localparam int AW  = $clog2(NV);        // vertex index width
	localparam int CW  = AW + 1;            // vertex count width
	localparam int SW  = $clog2(MD);        // slot index width
	localparam int DW  = $clog2(MD + 1);    // degree width
	localparam int ADW = AW + SW;           // adjacency address width
	localparam int VW  = 32;                // sample value width

	typedef logic [AW-1:0]        aw_t;
	typedef logic [CW-1:0]        cw_t;
	typedef logic [DW-1:0]        dw_t;
	typedef logic signed [VW-1:0] val_t;

	typedef enum logic [1:0] {
		K_LOAD = 2'd0,
		K_LINK = 2'd1,
		K_SORT = 2'd2,
		K_STEP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		R_SORTED = 3'd0,
		R_NODE   = 3'd1,
		R_EDGE   = 3'd2,
		R_ATTACH = 3'd3,
		R_ROOT   = 3'd4
	} rec_t;

	// operands and flags of the shared compare unit
	typedef struct packed {
		val_t a;
		val_t b;
	} cmp_op_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

	// one result word before the output register
	typedef struct packed {
		logic en;
		rec_t rec;
		aw_t  first;
		aw_t  second;
		val_t value;
		logic last;
	} res_t;

	function automatic val_t zx(input aw_t x);
		return val_t'({{(VW-AW){1'b0}}, x});
	endfunction

endpackage

// ===== design/mtuf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mtuf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/mtuf_cmp.sv =====
// Shared compare unit: signed less-than and equality on one operand pair.
// Depends on mtuf_pkg.
`timescale 1ns / 1ps

module mtuf_cmp (
	input  mtuf_pkg::cmp_op_t  op,
	output mtuf_pkg::cmp_res_t res
);

	assign res.lt = (op.a < op.b);
	assign res.eq = (op.a == op.b);

endmodule

// ===== design/merge_tree_union_find.sv =====
// Top level of the merge tree builder: sequencer, working registers, memories.
// Depends on mtuf_pkg, mtuf_ram and mtuf_cmp.
`timescale 1ns / 1ps

// Builds the join tree of a scalar field over a graph of up to 1024 vertices.
// Commands are taken when start is high and busy is low; busy stays high until
// every result word of the command has been registered for output. Each result
// word appears on the result ports for exactly one cycle with strobe high and
// cannot be held off, so the receiver must take every strobed word. After reset
// the block clears the degree table (busy high); config writes are taken at any
// time through cfg_valid/cfg_ready but must only be issued while the block is
// idle. All commands run on a single sequencer walking memories with registered
// reads and one shared comparator: load value writes the value RAM from idle;
// add link reads the degree, then compares each stored neighbor with the new
// one (a duplicate ends the scan early); sort does an identity fill of all 1024
// entries, then insertion sort in memory; process step reads the vertex and its
// neighbors, where each lower neighbor adds a find and a check against each
// component already found; then one find for a birth, three for a regular
// vertex, or two finds per lower component plus one more on a saddle; the last
// vertex adds one more find.
// Union-find uses path halving, so finds stay short in practice.
module merge_tree_union_find (
	input  logic                     clk,
	input  logic                     arst_n,
	// command channel
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               kind,
	input  logic [9:0]               vertex,
	input  logic signed [31:0]       sample_value,
	input  logic [9:0]               neighbor,
	// result channel
	output logic                     strobe,
	output logic [2:0]               record,
	output logic [9:0]               first_vertex,
	output logic [9:0]               second_vertex,
	output logic signed [31:0]       node_value,
	output logic                     last,
	// configuration: vertex_count
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [mtuf_pkg::CW-1:0]  cfg_data
);

	localparam int NST = 36;

	typedef enum logic [NST-1:0] {
		ST_CLR     = NST'(1) << 0,
		ST_IDLE    = NST'(1) << 1,
		ST_LK_DEG  = NST'(1) << 2,
		ST_LK_RD   = NST'(1) << 3,
		ST_LK_CMP  = NST'(1) << 4,
		ST_SO_INIT = NST'(1) << 5,
		ST_SO_X    = NST'(1) << 6,
		ST_SO_XV   = NST'(1) << 7,
		ST_SO_XK   = NST'(1) << 8,
		ST_SO_J    = NST'(1) << 9,
		ST_SO_Y    = NST'(1) << 10,
		ST_SO_CMP  = NST'(1) << 11,
		ST_PR_IDX  = NST'(1) << 12,
		ST_PR_DV   = NST'(1) << 13,
		ST_PR_NB   = NST'(1) << 14,
		ST_PR_K    = NST'(1) << 15,
		ST_PR_KV   = NST'(1) << 16,
		ST_PR_DUP  = NST'(1) << 17,
		ST_PR_CASE = NST'(1) << 18,
		ST_PR_ATT  = NST'(1) << 19,
		ST_PR_A1   = NST'(1) << 20,
		ST_PR_A2   = NST'(1) << 21,
		ST_PR_TRD  = NST'(1) << 22,
		ST_PR_TIN  = NST'(1) << 23,
		ST_PR_TSH  = NST'(1) << 24,
		ST_PR_EDGE = NST'(1) << 25,
		ST_PR_U0   = NST'(1) << 26,
		ST_PR_U1   = NST'(1) << 27,
		ST_PR_U2   = NST'(1) << 28,
		ST_PR_STOP = NST'(1) << 29,
		ST_PR_ROOT = NST'(1) << 30,
		ST_PR_RTOP = NST'(1) << 31,
		ST_PR_REDG = NST'(1) << 32,
		ST_F_RD    = NST'(1) << 33,
		ST_F_CHK   = NST'(1) << 34,
		ST_F_WR    = NST'(1) << 35
	} state_t;

	// ---------------- control registers ----------------
	state_t            state_q, state_d;
	state_t            ret_q, ret_d;       // return point of a find
	logic              armed_q, armed_d;
	mtuf_pkg::cw_t     vc_q;               // vertex_count register
	mtuf_pkg::cw_t     cnt_q, cnt_d;       // count latched by sort
	mtuf_pkg::cw_t     pos_q, pos_d;       // sweep position
	mtuf_pkg::aw_t     clr_q, clr_d;       // clear / init sweep counter
	logic              strobe_q;

	// ---------------- working registers ----------------
	mtuf_pkg::aw_t     fv_q, fv_d;         // find cursor / result
	mtuf_pkg::aw_t     idx_q, idx_d;       // current vertex or link source
	mtuf_pkg::aw_t     nb_q, nb_d;         // link target
	mtuf_pkg::val_t    vidx_q, vidx_d;     // value of current vertex
	mtuf_pkg::dw_t     deg_q, deg_d;
	mtuf_pkg::dw_t     d_q, d_d;           // neighbor slot counter
	mtuf_pkg::dw_t     nrep_q, nrep_d;     // lower components found
	mtuf_pkg::dw_t     i_q, i_d;
	mtuf_pkg::dw_t     j_q, j_d;
	mtuf_pkg::cw_t     si_q, si_d;         // sort outer index
	mtuf_pkg::cw_t     sj_q, sj_d;         // sort insert position
	mtuf_pkg::aw_t     x_q, x_d;           // sort element being inserted
	mtuf_pkg::val_t    kx_q, kx_d;         // its value
	mtuf_pkg::aw_t     y_q, y_d;           // tmp vertex (sort shift, union root)
	mtuf_pkg::aw_t     t_q, t_d;           // top node being carried
	mtuf_pkg::aw_t     reps_q [mtuf_pkg::MD];
	mtuf_pkg::aw_t     reps_d [mtuf_pkg::MD];
	mtuf_pkg::aw_t     tops_q [mtuf_pkg::MD];
	mtuf_pkg::aw_t     tops_d [mtuf_pkg::MD];

	// result output register
	mtuf_pkg::res_t    res_d;
	mtuf_pkg::rec_t    rec_q;
	mtuf_pkg::aw_t     first_q, second_q;
	mtuf_pkg::val_t    value_q;
	logic              last_q;

	// ---------------- memories ----------------
	logic                   val_we;
	mtuf_pkg::aw_t          val_waddr, val_raddr;
	mtuf_pkg::val_t         val_wdata, val_rdata;
	logic                   adj_we;
	logic [mtuf_pkg::ADW-1:0] adj_waddr, adj_raddr;
	mtuf_pkg::aw_t          adj_wdata, adj_rdata;
	logic                   deg_we;
	mtuf_pkg::aw_t          deg_waddr, deg_raddr;
	mtuf_pkg::dw_t          deg_wdata, deg_rdata;
	logic                   so_we;
	mtuf_pkg::aw_t          so_waddr, so_raddr, so_wdata, so_rdata;
	logic                   uf_we;
	mtuf_pkg::aw_t          uf_waddr, uf_raddr, uf_wdata, uf_rdata;
	logic                   top_we;
	mtuf_pkg::aw_t          top_waddr, top_raddr, top_wdata, top_rdata;

	mtuf_pkg::cmp_op_t      cmp_op;
	mtuf_pkg::cmp_res_t     cmp_res;

	logic                   fin;           // current vertex is the last one
	mtuf_pkg::dw_t          deg_clamp;

	mtuf_ram #(.DEPTH(mtuf_pkg::NV), .WIDTH(mtuf_pkg::VW)) u_val (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(val_raddr), .rdata(val_rdata)
	);

	mtuf_ram #(.DEPTH(mtuf_pkg::NV * mtuf_pkg::MD), .WIDTH(mtuf_pkg::AW)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);

	mtuf_ram #(.DEPTH(mtuf_pkg::NV), .WIDTH(mtuf_pkg::DW)) u_deg (
		.clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
		.raddr(deg_raddr), .rdata(deg_rdata)
	);

	mtuf_ram #(.DEPTH(mtuf_pkg::NV), .WIDTH(mtuf_pkg::AW)) u_sorted (
		.clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
		.raddr(so_raddr), .rdata(so_rdata)
	);

	mtuf_ram #(.DEPTH(mtuf_pkg::NV), .WIDTH(mtuf_pkg::AW)) u_parent (
		.clk(clk), .we(uf_we), .waddr(uf_waddr), .wdata(uf_wdata),
		.raddr(uf_raddr), .rdata(uf_rdata)
	);

	mtuf_ram #(.DEPTH(mtuf_pkg::NV), .WIDTH(mtuf_pkg::AW)) u_top (
		.clk(clk), .we(top_we), .waddr(top_waddr), .wdata(top_wdata),
		.raddr(top_raddr), .rdata(top_rdata)
	);

	mtuf_cmp u_cmp (
		.op(cmp_op),
		.res(cmp_res)
	);

	function automatic mtuf_pkg::val_t val_t_cnt(input mtuf_pkg::cw_t c);
		return mtuf_pkg::val_t'({{(mtuf_pkg::VW-mtuf_pkg::CW){1'b0}}, c});
	endfunction

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign fin       = ((pos_q + mtuf_pkg::CW'(1)) == cnt_q);
	assign deg_clamp = (deg_rdata > mtuf_pkg::DW'(mtuf_pkg::MD))
		? mtuf_pkg::DW'(mtuf_pkg::MD) : deg_rdata;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		armed_d = armed_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		clr_d   = clr_q;
		fv_d    = fv_q;
		idx_d   = idx_q;
		nb_d    = nb_q;
		vidx_d  = vidx_q;
		deg_d   = deg_q;
		d_d     = d_q;
		nrep_d  = nrep_q;
		i_d     = i_q;
		j_d     = j_q;
		si_d    = si_q;
		sj_d    = sj_q;
		x_d     = x_q;
		kx_d    = kx_q;
		y_d     = y_q;
		t_d     = t_q;
		reps_d  = reps_q;
		tops_d  = tops_q;

		res_d = '0;

		val_we = 1'b0; val_waddr = vertex; val_wdata = sample_value; val_raddr = idx_q;
		adj_we = 1'b0; adj_waddr = {idx_q, deg_q[mtuf_pkg::SW-1:0]}; adj_wdata = nb_q;
		adj_raddr = {idx_q, d_q[mtuf_pkg::SW-1:0]};
		deg_we = 1'b0; deg_waddr = clr_q; deg_wdata = '0; deg_raddr = idx_q;
		so_we = 1'b0; so_waddr = clr_q; so_wdata = clr_q; so_raddr = x_q;
		uf_we = 1'b0; uf_waddr = clr_q; uf_wdata = clr_q; uf_raddr = fv_q;
		top_we = 1'b0; top_waddr = fv_q; top_wdata = t_q; top_raddr = fv_q;

		cmp_op.a = '0;
		cmp_op.b = '0;

		case (state_q)
			ST_CLR: begin
				deg_we = 1'b1;
				clr_d  = clr_q + mtuf_pkg::AW'(1);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (start) begin
					case (mtuf_pkg::kind_t'(kind))
						mtuf_pkg::K_LOAD: begin
							val_we = 1'b1;
						end
						mtuf_pkg::K_LINK: begin
							deg_raddr = vertex;
							idx_d     = vertex;
							nb_d      = neighbor;
							state_d   = ST_LK_DEG;
						end
						mtuf_pkg::K_SORT: begin
							clr_d   = '0;
							cnt_d   = vc_q;
							armed_d = 1'b0;
							state_d = ST_SO_INIT;
						end
						mtuf_pkg::K_STEP: begin
							// no result before a sort or past the end
							if (armed_q && (pos_q < cnt_q)) begin
								so_raddr = pos_q[mtuf_pkg::AW-1:0];
								state_d  = ST_PR_IDX;
							end
						end
						default: begin
						end
					endcase
				end
			end

			// ---- add link ----
			ST_LK_DEG: begin
				deg_d   = deg_clamp;
				d_d     = '0;
				state_d = ST_LK_RD;
			end

			ST_LK_RD: begin
				if (d_q < deg_q) begin
					state_d = ST_LK_CMP;
				end else begin
					if (deg_q < mtuf_pkg::DW'(mtuf_pkg::MD)) begin
						adj_we    = 1'b1;
						deg_we    = 1'b1;
						deg_waddr = idx_q;
						deg_wdata = deg_q + mtuf_pkg::DW'(1);
					end
					state_d = ST_IDLE;
				end
			end

			ST_LK_CMP: begin
				cmp_op.a = mtuf_pkg::zx(adj_rdata);
				cmp_op.b = mtuf_pkg::zx(nb_q);
				if (cmp_res.eq) begin
					state_d = ST_IDLE;      // duplicate link
				end else begin
					d_d     = d_q + mtuf_pkg::DW'(1);
					state_d = ST_LK_RD;
				end
			end

			// ---- sort: identity fill, then insertion sort in memory ----
			ST_SO_INIT: begin
				so_we = 1'b1;
				uf_we = 1'b1;
				clr_d = clr_q + mtuf_pkg::AW'(1);
				if (clr_q == '1) begin
					si_d    = mtuf_pkg::CW'(1);
					state_d = ST_SO_X;
				end
			end

			ST_SO_X: begin
				if (si_q >= cnt_q) begin
					res_d.en   = 1'b1;
					res_d.rec  = mtuf_pkg::R_SORTED;
					res_d.last = 1'b1;
					armed_d    = 1'b1;
					pos_d      = '0;
					state_d    = ST_IDLE;
				end else begin
					so_raddr = si_q[mtuf_pkg::AW-1:0];
					state_d  = ST_SO_XV;
				end
			end

			ST_SO_XV: begin
				x_d       = so_rdata;
				val_raddr = so_rdata;
				state_d   = ST_SO_XK;
			end

			ST_SO_XK: begin
				kx_d    = val_rdata;
				sj_d    = si_q;
				state_d = ST_SO_J;
			end

			ST_SO_J: begin
				if (sj_q == '0) begin
					so_we    = 1'b1;
					so_waddr = '0;
					so_wdata = x_q;
					si_d     = si_q + mtuf_pkg::CW'(1);
					state_d  = ST_SO_X;
				end else begin
					so_raddr = sj_q[mtuf_pkg::AW-1:0] - mtuf_pkg::AW'(1);
					state_d  = ST_SO_Y;
				end
			end

			ST_SO_Y: begin
				y_d       = so_rdata;
				val_raddr = so_rdata;
				state_d   = ST_SO_CMP;
			end

			ST_SO_CMP: begin
				// shift while the left neighbor is strictly greater (stable)
				cmp_op.a = kx_q;
				cmp_op.b = val_rdata;
				so_we    = 1'b1;
				so_waddr = sj_q[mtuf_pkg::AW-1:0];
				if (cmp_res.lt) begin
					so_wdata = y_q;
					sj_d     = sj_q - mtuf_pkg::CW'(1);
					state_d  = ST_SO_J;
				end else begin
					so_wdata = x_q;
					si_d     = si_q + mtuf_pkg::CW'(1);
					state_d  = ST_SO_X;
				end
			end

			// ---- sweep step ----
			ST_PR_IDX: begin
				idx_d     = so_rdata;
				deg_raddr = so_rdata;
				val_raddr = so_rdata;
				state_d   = ST_PR_DV;
			end

			ST_PR_DV: begin
				deg_d   = deg_clamp;
				vidx_d  = val_rdata;
				d_d     = '0;
				nrep_d  = '0;
				state_d = ST_PR_NB;
			end

			ST_PR_NB: begin
				if (d_q < deg_q) begin
					state_d = ST_PR_K;
				end else begin
					state_d = ST_PR_CASE;
				end
			end

			ST_PR_K: begin
				cmp_op.a  = mtuf_pkg::zx(adj_rdata);
				cmp_op.b  = val_t_cnt(cnt_q);
				y_d       = adj_rdata;
				val_raddr = adj_rdata;
				if (cmp_res.lt) begin
					state_d = ST_PR_KV;
				end else begin
					d_d     = d_q + mtuf_pkg::DW'(1);
					state_d = ST_PR_NB;
				end
			end

			ST_PR_KV: begin
				cmp_op.a = val_rdata;
				cmp_op.b = vidx_q;
				if (cmp_res.lt) begin
					fv_d    = y_q;
					ret_d   = ST_PR_DUP;
					i_d     = '0;
					state_d = ST_F_RD;
				end else begin
					d_d     = d_q + mtuf_pkg::DW'(1);
					state_d = ST_PR_NB;
				end
			end

			ST_PR_DUP: begin
				if (i_q == nrep_q) begin
					reps_d[nrep_q[mtuf_pkg::SW-1:0]] = fv_q;
					nrep_d  = nrep_q + mtuf_pkg::DW'(1);
					d_d     = d_q + mtuf_pkg::DW'(1);
					state_d = ST_PR_NB;
				end else begin
					cmp_op.a = mtuf_pkg::zx(reps_q[i_q[mtuf_pkg::SW-1:0]]);
					cmp_op.b = mtuf_pkg::zx(fv_q);
					if (cmp_res.eq) begin
						d_d     = d_q + mtuf_pkg::DW'(1);
						state_d = ST_PR_NB;
					end else begin
						i_d = i_q + mtuf_pkg::DW'(1);
					end
				end
			end

			ST_PR_CASE: begin
				if (nrep_q == '0) begin
					// birth
					res_d.en    = 1'b1;
					res_d.rec   = mtuf_pkg::R_NODE;
					res_d.first = idx_q;
					res_d.value = vidx_q;
					res_d.last  = !fin;
					t_d         = idx_q;
					fv_d        = idx_q;
					ret_d       = ST_PR_STOP;
					state_d     = ST_F_RD;
				end else if (nrep_q == mtuf_pkg::DW'(1)) begin
					top_raddr = reps_q[0];
					state_d   = ST_PR_ATT;
				end else begin
					// saddle
					res_d.en    = 1'b1;
					res_d.rec   = mtuf_pkg::R_NODE;
					res_d.first = idx_q;
					res_d.value = vidx_q;
					i_d         = '0;
					state_d     = ST_PR_TRD;
				end
			end

			// regular vertex
			ST_PR_ATT: begin
				res_d.en     = 1'b1;
				res_d.rec    = mtuf_pkg::R_ATTACH;
				res_d.first  = idx_q;
				res_d.second = top_rdata;
				res_d.last   = !fin;
				t_d          = top_rdata;
				fv_d         = idx_q;
				ret_d        = ST_PR_A1;
				state_d      = ST_F_RD;
			end

			ST_PR_A1: begin
				y_d     = fv_q;            // root of the vertex
				fv_d    = reps_q[0];
				ret_d   = ST_PR_A2;
				state_d = ST_F_RD;
			end

			ST_PR_A2: begin
				cmp_op.a = mtuf_pkg::zx(fv_q);
				cmp_op.b = mtuf_pkg::zx(y_q);
				if (!cmp_res.eq) begin
					uf_we    = 1'b1;
					uf_waddr = y_q;
					uf_wdata = fv_q;
				end
				fv_d    = idx_q;
				ret_d   = ST_PR_STOP;
				state_d = ST_F_RD;
			end

			// saddle: gather component tops in ascending order
			ST_PR_TRD: begin
				if (i_q == nrep_q) begin
					i_d     = '0;
					state_d = ST_PR_EDGE;
				end else begin
					top_raddr = reps_q[i_q[mtuf_pkg::SW-1:0]];
					state_d   = ST_PR_TIN;
				end
			end

			ST_PR_TIN: begin
				t_d     = top_rdata;
				j_d     = i_q;
				state_d = ST_PR_TSH;
			end

			ST_PR_TSH: begin
				cmp_op.a = mtuf_pkg::zx(t_q);
				cmp_op.b = mtuf_pkg::zx(tops_q[j_q[mtuf_pkg::SW-1:0] - mtuf_pkg::SW'(1)]);
				if ((j_q != '0) && cmp_res.lt) begin
					tops_d[j_q[mtuf_pkg::SW-1:0]] =
						tops_q[j_q[mtuf_pkg::SW-1:0] - mtuf_pkg::SW'(1)];
					j_d = j_q - mtuf_pkg::DW'(1);
				end else begin
					tops_d[j_q[mtuf_pkg::SW-1:0]] = t_q;
					i_d     = i_q + mtuf_pkg::DW'(1);
					state_d = ST_PR_TRD;
				end
			end

			ST_PR_EDGE: begin
				res_d.en     = 1'b1;
				res_d.rec    = mtuf_pkg::R_EDGE;
				res_d.first  = tops_q[i_q[mtuf_pkg::SW-1:0]];
				res_d.second = idx_q;
				res_d.last   = (i_q == (nrep_q - mtuf_pkg::DW'(1))) && !fin;
				if (i_q == (nrep_q - mtuf_pkg::DW'(1))) begin
					i_d     = '0;
					state_d = ST_PR_U0;
				end else begin
					i_d = i_q + mtuf_pkg::DW'(1);
				end
			end

			// saddle: merge every lower component under the vertex's root
			ST_PR_U0: begin
				fv_d    = reps_q[i_q[mtuf_pkg::SW-1:0]];
				ret_d   = ST_PR_U1;
				state_d = ST_F_RD;
			end

			ST_PR_U1: begin
				y_d     = fv_q;
				fv_d    = idx_q;
				ret_d   = ST_PR_U2;
				state_d = ST_F_RD;
			end

			ST_PR_U2: begin
				cmp_op.a = mtuf_pkg::zx(y_q);
				cmp_op.b = mtuf_pkg::zx(fv_q);
				if (!cmp_res.eq) begin
					uf_we    = 1'b1;
					uf_waddr = y_q;
					uf_wdata = fv_q;
				end
				if (i_q == (nrep_q - mtuf_pkg::DW'(1))) begin
					t_d     = idx_q;
					fv_d    = idx_q;
					ret_d   = ST_PR_STOP;
					state_d = ST_F_RD;
				end else begin
					i_d     = i_q + mtuf_pkg::DW'(1);
					state_d = ST_PR_U0;
				end
			end

			ST_PR_STOP: begin
				top_we = 1'b1;
				pos_d  = pos_q + mtuf_pkg::CW'(1);
				if (fin) begin
					state_d = ST_PR_ROOT;
				end else begin
					state_d = ST_IDLE;
				end
			end

			ST_PR_ROOT: begin
				res_d.en    = 1'b1;
				res_d.rec   = mtuf_pkg::R_ROOT;
				res_d.first = idx_q;
				res_d.value = vidx_q;
				fv_d        = idx_q;
				ret_d       = ST_PR_RTOP;
				state_d     = ST_F_RD;
			end

			ST_PR_RTOP: begin
				state_d = ST_PR_REDG;
			end

			ST_PR_REDG: begin
				res_d.en     = 1'b1;
				res_d.rec    = mtuf_pkg::R_EDGE;
				res_d.first  = top_rdata;
				res_d.second = idx_q;
				res_d.last   = 1'b1;
				state_d      = ST_IDLE;
			end

			// ---- find with path halving ----
			ST_F_RD: begin
				state_d = ST_F_CHK;
			end

			ST_F_CHK: begin
				cmp_op.a = mtuf_pkg::zx(uf_rdata);
				cmp_op.b = mtuf_pkg::zx(fv_q);
				if (cmp_res.eq) begin
					state_d = ret_q;
				end else begin
					uf_raddr = uf_rdata;
					y_d      = y_q;
					state_d  = ST_F_WR;
				end
			end

			ST_F_WR: begin
				uf_we    = 1'b1;
				uf_waddr = fv_q;
				uf_wdata = uf_rdata;
				fv_d     = uf_rdata;
				state_d  = ST_F_RD;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			ret_q    <= ST_IDLE;
			armed_q  <= 1'b0;
			vc_q     <= mtuf_pkg::CW'(1);
			cnt_q    <= '0;
			pos_q    <= '0;
			clr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			armed_q  <= armed_d;
			cnt_q    <= cnt_d;
			pos_q    <= pos_d;
			clr_q    <= clr_d;
			strobe_q <= res_d.en;
			// vertex_count is clamped to the supported range on write
			if (cfg_valid) begin
				if (cfg_data == '0) begin
					vc_q <= mtuf_pkg::CW'(1);
				end else if (cfg_data > mtuf_pkg::CW'(mtuf_pkg::NV)) begin
					vc_q <= mtuf_pkg::CW'(mtuf_pkg::NV);
				end else begin
					vc_q <= cfg_data;
				end
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		fv_q     <= fv_d;
		idx_q    <= idx_d;
		nb_q     <= nb_d;
		vidx_q   <= vidx_d;
		deg_q    <= deg_d;
		d_q      <= d_d;
		nrep_q   <= nrep_d;
		i_q      <= i_d;
		j_q      <= j_d;
		si_q     <= si_d;
		sj_q     <= sj_d;
		x_q      <= x_d;
		kx_q     <= kx_d;
		y_q      <= y_d;
		t_q      <= t_d;
		reps_q   <= reps_d;
		tops_q   <= tops_d;
		rec_q    <= res_d.rec;
		first_q  <= res_d.first;
		second_q <= res_d.second;
		value_q  <= res_d.value;
		last_q   <= res_d.last;
	end

	assign strobe        = strobe_q;
	assign record        = rec_q;
	assign first_vertex  = first_q;
	assign second_vertex = second_q;
	assign node_value    = value_q;
	assign last          = last_q;

endmodule

// ===== sim/merge_tree_union_find_tb.sv =====
// Self-checking testbench for merge_tree_union_find: loads graphs, sorts, sweeps,
// and checks every result word against an in-bench join tree predictor.
// Depends on mtuf_pkg and the merge_tree_union_find RTL.
`timescale 1ns / 1ps

module merge_tree_union_find_tb;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int SETTLE_CYCLES = 24;
	localparam int TAIL_CYCLES = 300;

	// what the driver queue holds: a command word, a config write, or a drain pause
	localparam int OP_CMD   = 0;
	localparam int OP_CFG   = 1;
	localparam int OP_PAUSE = 2;

	typedef struct {
		int              op;
		mtuf_pkg::kind_t k;
		mtuf_pkg::aw_t   v;
		mtuf_pkg::val_t  val;
		mtuf_pkg::aw_t   nb;
		int              gap;
		mtuf_pkg::cw_t   cfgv;
	} pend_t;

	typedef struct {
		mtuf_pkg::rec_t rec;
		mtuf_pkg::aw_t  first;
		mtuf_pkg::aw_t  second;
		mtuf_pkg::val_t value;
		logic           last;
	} tree_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] kind = mtuf_pkg::K_LOAD;
	logic [9:0] vertex = '0;
	logic signed [31:0] sample_value = '0;
	logic [9:0] neighbor = '0;
	logic cfg_valid = 1'b0;
	logic [mtuf_pkg::CW-1:0] cfg_data = '0;
	logic busy, strobe, last, cfg_ready;
	logic [2:0] record;
	logic [9:0] first_vertex, second_vertex;
	logic signed [31:0] node_value;

	merge_tree_union_find DUT (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .kind(kind), .vertex(vertex),
		.sample_value(sample_value), .neighbor(neighbor),
		.strobe(strobe), .record(record), .first_vertex(first_vertex),
		.second_vertex(second_vertex), .node_value(node_value), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	pend_t      pending[$];
	tree_word_t tree_expected[$];
	int         mismatches = 0;
	int         quiet = 0;
	int         cycles = 0;

	// ---------------- join tree predictor state ----------------
	mtuf_pkg::val_t vals[mtuf_pkg::NV];
	mtuf_pkg::aw_t  adj[mtuf_pkg::NV][mtuf_pkg::MD];
	int             degc[mtuf_pkg::NV];
	mtuf_pkg::aw_t  order[mtuf_pkg::NV];
	mtuf_pkg::aw_t  parent[mtuf_pkg::NV];
	mtuf_pkg::aw_t  topn[mtuf_pkg::NV];
	int             sweep_pos;
	int             count_reg;
	int             sweep_n;
	bit             armed;

	function automatic void emit_word(ref tree_word_t q[$], input mtuf_pkg::rec_t r,
		input mtuf_pkg::aw_t a, input mtuf_pkg::aw_t b, input mtuf_pkg::val_t x);
		tree_word_t w;
		w.rec = r; w.first = a; w.second = b; w.value = x; w.last = 1'b0;
		q = {q, w};
	endfunction

	// union-find root with path halving, same hops as the block
	function automatic mtuf_pkg::aw_t find_root(input mtuf_pkg::aw_t v0);
		mtuf_pkg::aw_t v, p;
		v = v0;
		for (int s = 0; s < mtuf_pkg::NV; s++) begin
			p = parent[v];
			if (p == v) break;
			parent[v] = parent[p];
			v = parent[p];
		end
		return v;
	endfunction

	function automatic void sort_vertices();
		mtuf_pkg::aw_t x;
		int j;
		for (int i = 0; i < count_reg; i++) order[i] = mtuf_pkg::aw_t'(i);
		for (int i = 1; i < count_reg; i++) begin
			x = order[i];
			j = i;
			while (j > 0 && vals[order[j-1]] > vals[x]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = x;
		end
		for (int i = 0; i < mtuf_pkg::NV; i++) parent[i] = mtuf_pkg::aw_t'(i);
		sweep_pos = 0;
		sweep_n = count_reg;
		armed = 1'b1;
	endfunction

	function automatic void sweep_vertex(ref tree_word_t q[$]);
		mtuf_pkg::aw_t reps[mtuf_pkg::MD], tops[mtuf_pkg::MD];
		int nrep, deg, j;
		mtuf_pkg::aw_t idx, k, r, ri, t;
		bit seen;
		nrep = 0;
		if (!armed || sweep_pos >= sweep_n) return;
		idx = order[sweep_pos];
		deg = degc[idx];
		for (int d = 0; d < deg; d++) begin
			k = adj[idx][d];
			if (int'(k) >= sweep_n || vals[k] >= vals[idx]) continue;
			r = find_root(k);
			seen = 1'b0;
			for (int i = 0; i < nrep; i++) if (reps[i] == r) seen = 1'b1;
			if (!seen) begin
				reps[nrep] = r;
				nrep++;
			end
		end
		if (nrep == 0) begin
			// birth of a new component
			emit_word(q, mtuf_pkg::R_NODE, idx, '0, vals[idx]);
			topn[find_root(idx)] = idx;
		end else if (nrep > 1) begin
			// saddle: node plus one edge per component, lower node ascending
			emit_word(q, mtuf_pkg::R_NODE, idx, '0, vals[idx]);
			for (int i = 0; i < nrep; i++) begin
				t = topn[reps[i]];
				j = i;
				while (j > 0 && tops[j-1] > t) begin
					tops[j] = tops[j-1];
					j--;
				end
				tops[j] = t;
			end
			for (int i = 0; i < nrep; i++) emit_word(q, mtuf_pkg::R_EDGE, tops[i], idx, '0);
			for (int i = 0; i < nrep; i++) begin
				r = find_root(reps[i]);
				ri = find_root(idx);
				if (r != ri) parent[r] = ri;
			end
			topn[find_root(idx)] = idx;
		end else begin
			// regular vertex joins the one component below it
			t = topn[reps[0]];
			emit_word(q, mtuf_pkg::R_ATTACH, idx, t, '0);
			ri = find_root(idx);
			r = find_root(reps[0]);
			if (r != ri) parent[ri] = r;
			topn[find_root(idx)] = t;
		end
		sweep_pos++;
		if (sweep_pos == sweep_n) begin
			// root record and its edge; a self-loop when the root is a node
			emit_word(q, mtuf_pkg::R_ROOT, idx, '0, vals[idx]);
			emit_word(q, mtuf_pkg::R_EDGE, topn[find_root(idx)], idx, '0);
		end
	endfunction

	function automatic void predict_cmd(input pend_t c);
		tree_word_t q[$];
		bit dup;
		case (c.k)
			mtuf_pkg::K_LOAD: begin
				vals[c.v] = c.val;
			end
			mtuf_pkg::K_LINK: begin
				dup = 1'b0;
				for (int d = 0; d < degc[c.v]; d++) if (adj[c.v][d] == c.nb) dup = 1'b1;
				if (!dup && degc[c.v] < mtuf_pkg::MD) begin
					adj[c.v][degc[c.v]] = c.nb;
					degc[c.v]++;
				end
			end
			mtuf_pkg::K_SORT: begin
				sort_vertices();
				emit_word(q, mtuf_pkg::R_SORTED, '0, '0, '0);
			end
			default: begin
				sweep_vertex(q);
			end
		endcase
		if (q.size() > 0) q[q.size()-1].last = 1'b1;
		foreach (q[i]) tree_expected = {tree_expected, q[i]};
	endfunction

	initial begin
		for (int i = 0; i < mtuf_pkg::NV; i++) begin
			vals[i] = '0; degc[i] = 0; order[i] = '0; topn[i] = '0;
			parent[i] = mtuf_pkg::aw_t'(i);
		end
		sweep_pos = 0; count_reg = 1; sweep_n = 0; armed = 1'b0;
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		pend_t h;
		logic nxt_start;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nxt_start = 1'b0;
			if (start && !busy) begin
				predict_cmd(pending.pop_front());
			end
			if (cfg_valid && cfg_ready) begin
				h = pending.pop_front();
				count_reg = (h.cfgv < 1) ? 1
					: ((h.cfgv > mtuf_pkg::NV) ? mtuf_pkg::NV : int'(h.cfgv));
				cfg_valid <= 1'b0;
			end
			quiet <= (busy || start || cfg_valid || tree_expected.size() != 0) ? 0 : quiet + 1;
			if (pending.size() > 0 && !(cfg_valid && !cfg_ready)) begin
				h = pending[0];
				if (h.op == OP_CMD) begin
					if ((start && busy) || $urandom_range(99) >= h.gap) begin
						nxt_start = 1'b1;
						kind <= h.k;
						vertex <= h.v;
						sample_value <= h.val;
						neighbor <= h.nb;
					end
				end else if (quiet >= SETTLE_CYCLES && !(cfg_valid && cfg_ready)) begin
					// drain point reached: pauses just end, config goes out now
					if (h.op == OP_PAUSE) begin
						void'(pending.pop_front());
					end else begin
						cfg_valid <= 1'b1;
						cfg_data <= h.cfgv;
					end
				end
			end
			start <= nxt_start;
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		tree_word_t e;
		if (arst_n && strobe) begin
			if (tree_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word rec=%0d first=%0d second=%0d value=%0d last=%0b",
						record, first_vertex, second_vertex, node_value, last);
			end else begin
				e = tree_expected.pop_front();
				if (record !== e.rec || first_vertex !== e.first || second_vertex !== e.second
					|| node_value !== e.value || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp rec=%0d f=%0d s=%0d v=%0d l=%0b",
							e.rec, e.first, e.second, e.value, e.last,
							" got rec=%0d f=%0d s=%0d v=%0d l=%0b",
							record, first_vertex, second_vertex, node_value, last);
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	int cur_gap = 0;

	task automatic put_cmd(input mtuf_pkg::kind_t k, input int v, input mtuf_pkg::val_t x,
		input int nb);
		pend_t p;
		p.op = OP_CMD; p.k = k; p.v = mtuf_pkg::aw_t'(v); p.val = x;
		p.nb = mtuf_pkg::aw_t'(nb);
		p.gap = cur_gap; p.cfgv = '0;
		pending = {pending, p};
	endtask

	task automatic put_ctl(input int op, input int cv);
		pend_t p;
		p.op = op; p.k = mtuf_pkg::K_LOAD; p.v = '0; p.val = '0; p.nb = '0; p.gap = 0;
		p.cfgv = mtuf_pkg::cw_t'(cv);
		pending = {pending, p};
	endtask

	function automatic mtuf_pkg::val_t pick_value();
		case ($urandom_range(9))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2, 3: return mtuf_pkg::val_t'($urandom);
			default: return mtuf_pkg::val_t'($signed($urandom_range(6)) - 3);
		endcase
	endfunction

	// one graph: config, values, links, sort, full sweep plus overrun steps
	task automatic graph_session(input int n);
		int links;
		put_ctl(OP_CFG, n);
		for (int i = 0; i < n; i++) put_cmd(mtuf_pkg::K_LOAD, i, pick_value(), 0);
		links = $urandom_range(3 * n);
		for (int i = 0; i < links; i++)
			put_cmd(mtuf_pkg::K_LINK, $urandom_range(n - 1), 0, $urandom_range(n + 1));
		put_cmd(mtuf_pkg::K_SORT, $urandom_range(1023), mtuf_pkg::val_t'($urandom),
			$urandom_range(1023));
		for (int i = 0; i < n + 2; i++) begin
			put_cmd(mtuf_pkg::K_STEP, $urandom_range(1023), mtuf_pkg::val_t'($urandom),
				$urandom_range(1023));
			case ($urandom_range(9))
				0: put_cmd(mtuf_pkg::K_LOAD, $urandom_range(n - 1), pick_value(), 0);
				1: put_cmd(mtuf_pkg::K_LINK, $urandom_range(1023), 0, $urandom_range(1023));
				default: ;
			endcase
		end
	endtask

	initial begin
		int gaps[4];
		gaps = '{0, 76, 34, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: step before any sort, single-vertex sweep with root self-loop
		put_cmd(mtuf_pkg::K_STEP, 0, 0, 0);
		put_cmd(mtuf_pkg::K_LOAD, 0, 32'sh80000000, 0);
		put_cmd(mtuf_pkg::K_SORT, 0, 0, 0);
		put_cmd(mtuf_pkg::K_STEP, 1023, 32'shffffffff, 1023);
		put_cmd(mtuf_pkg::K_STEP, 0, 0, 0);
		put_cmd(mtuf_pkg::K_LOAD, 0, 32'sh7fffffff, 0);
		put_cmd(mtuf_pkg::K_LINK, 0, 0, 0);
		put_ctl(OP_PAUSE, 0);
		// directed: stable tie, saddle, duplicate link, link past degree limit
		put_ctl(OP_CFG, 3);
		put_cmd(mtuf_pkg::K_LOAD, 0, 1, 0);
		put_cmd(mtuf_pkg::K_LOAD, 1, 1, 0);
		put_cmd(mtuf_pkg::K_LOAD, 2, 5, 0);
		put_cmd(mtuf_pkg::K_LINK, 2, 0, 0);
		put_cmd(mtuf_pkg::K_LINK, 2, 1, 1);
		put_cmd(mtuf_pkg::K_LINK, 2, 0, 0);
		put_cmd(mtuf_pkg::K_LINK, 0, 0, 2);
		for (int i = 0; i < 9; i++) put_cmd(mtuf_pkg::K_LINK, 3, 0, i);
		put_cmd(mtuf_pkg::K_SORT, 0, 0, 0);
		for (int i = 0; i < 4; i++) put_cmd(mtuf_pkg::K_STEP, 0, 0, 0);

		// clamp at the low extreme
		put_ctl(OP_CFG, 0);
		put_cmd(mtuf_pkg::K_SORT, 0, 0, 0);
		put_cmd(mtuf_pkg::K_STEP, 0, 0, 0);

		// random graphs through the idle phases
		for (int s = 0; s < 11; s++) begin
			cur_gap = gaps[s % 4];
			graph_session($urandom_range(2, 12));
			if (s % 5 == 2) put_ctl(OP_PAUSE, 0);
		end

		cur_gap = 76;
		graph_session(5);

		while (pending.size() != 0 || tree_expected.size() != 0 || start)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && tree_expected.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== merge_tree_union_find.f =====
design/mtuf_pkg.sv
design/mtuf_ram.sv
design/mtuf_cmp.sv
design/merge_tree_union_find.sv
sim/merge_tree_union_find_tb.sv
